FILE: hdl/mfr_pkg.sv
// ----------------------------------------------------------------------------
// Manchester frame receiver package
// Shared status codes, word layout widths and stage structs.
// ----------------------------------------------------------------------------
package mfr_pkg;

	localparam int CfgWidth      = 16;
	localparam int CfgIndexWidth = 4;
	localparam int TimeWidth     = 32;
	localparam int DataWidth     = 34;
	localparam int InTdataWidth  = 40;
	localparam int OutTdataWidth = 40;

	localparam logic [CfgIndexWidth-1:0] REG_HALF_WINDOW = 4'd0;
	localparam logic [CfgIndexWidth-1:0] REG_LATE_LIMIT  = 4'd1;

	localparam logic [CfgWidth-1:0] HALF_WINDOW_RESET = 16'd900;
	localparam logic [CfgWidth-1:0] LATE_LIMIT_RESET  = 16'd1150;

	localparam logic OP_EDGE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	localparam logic [1:0] STATUS_NONE    = 2'd0;
	localparam logic [1:0] STATUS_EARLY   = 2'd1;
	localparam logic [1:0] STATUS_LATE    = 2'd2;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

	typedef struct packed {
		logic                 op;
		logic [TimeWidth-1:0] edge_time;
		logic                 line_level;
	} item_t;

	typedef struct packed {
		logic                 frame_valid;
		logic [DataWidth-1:0] frame_data;
		logic                 receiving;
		logic [1:0]           status;
	} result_t;

endpackage

FILE: hdl/mfr_core.sv
// ----------------------------------------------------------------------------
// Manchester frame receiver core
// Frame state registers and the single-pass edge decode for one word.
// ----------------------------------------------------------------------------
module mfr_core #(
	parameter int FRAME_BITS = 34
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  advance,
	input  mfr_pkg::item_t                        item,
	input  logic [mfr_pkg::CfgWidth-1:0]          half_window_us,
	input  logic [mfr_pkg::CfgWidth-1:0]          late_limit_us,
	output mfr_pkg::result_t                      result
);

	localparam int CountWidth = $clog2(FRAME_BITS + 1);
	localparam logic [CountWidth-1:0] LastCount = CountWidth'(FRAME_BITS);

	logic                          busy_q;
	logic                          error_hold_q;
	logic                          mid_bit_seen_q;
	logic [CountWidth-1:0]         bit_count_q;
	logic [FRAME_BITS-1:0]         shift_q;
	logic [mfr_pkg::TimeWidth-1:0] time_ref_q;
	logic [1:0]                    error_code_q;

	logic                          busy_d;
	logic                          error_hold_d;
	logic                          mid_bit_seen_d;
	logic [CountWidth-1:0]         bit_count_d;
	logic [FRAME_BITS-1:0]         shift_d;
	logic [mfr_pkg::TimeWidth-1:0] time_ref_d;
	logic [1:0]                    error_code_d;

	logic [mfr_pkg::TimeWidth-1:0] dt;
	logic [FRAME_BITS-1:0]         shift_in;
	logic [CountWidth-1:0]         count_inc;
	logic [63:0]                   shift_wide;

	assign dt         = item.edge_time - time_ref_q;
	assign shift_in   = {shift_q[FRAME_BITS-2:0], ~item.line_level};
	assign count_inc  = bit_count_q + CountWidth'(1);
	assign shift_wide = 64'(shift_in);

	always_comb begin
		busy_d             = busy_q;
		error_hold_d       = error_hold_q;
		mid_bit_seen_d     = mid_bit_seen_q;
		bit_count_d        = bit_count_q;
		shift_d            = shift_q;
		time_ref_d         = time_ref_q;
		error_code_d       = error_code_q;
		result.frame_valid = 1'b0;
		result.frame_data  = '0;
		priority if (item.op == mfr_pkg::OP_TIMEOUT) begin
			if (busy_q) begin
				error_code_d = mfr_pkg::STATUS_TIMEOUT;
				error_hold_d = 1'b0;
				busy_d       = 1'b0;
			end
		end else if (error_hold_q) begin
			error_hold_d = 1'b1;
		end else if (!busy_q) begin
			if (item.line_level) begin
				busy_d         = 1'b1;
				bit_count_d    = '0;
				shift_d        = '0;
				mid_bit_seen_d = 1'b0;
				error_code_d   = mfr_pkg::STATUS_NONE;
			end
		end else if (bit_count_q == '0) begin
			time_ref_d  = item.edge_time;
			bit_count_d = CountWidth'(1);
			shift_d     = shift_in;
		end else if (dt < 32'(half_window_us)) begin
			if (!mid_bit_seen_q) begin
				mid_bit_seen_d = 1'b1;
			end else begin
				error_hold_d = 1'b1;
				error_code_d = mfr_pkg::STATUS_EARLY;
			end
		end else if (dt < 32'(late_limit_us)) begin
			shift_d     = shift_in;
			bit_count_d = count_inc;
			if (count_inc == LastCount) begin
				result.frame_valid = 1'b1;
				result.frame_data  = shift_wide[mfr_pkg::DataWidth-1:0];
				busy_d             = 1'b0;
			end else begin
				time_ref_d     = item.edge_time;
				mid_bit_seen_d = 1'b0;
			end
		end else begin
			error_hold_d = 1'b1;
			error_code_d = mfr_pkg::STATUS_LATE;
		end
		result.receiving = busy_d | error_hold_d;
		result.status    = error_code_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			error_hold_q   <= 1'b0;
			mid_bit_seen_q <= 1'b0;
			bit_count_q    <= '0;
			shift_q        <= '0;
			time_ref_q     <= '0;
			error_code_q   <= mfr_pkg::STATUS_NONE;
		end else if (advance) begin
			busy_q         <= busy_d;
			error_hold_q   <= error_hold_d;
			mid_bit_seen_q <= mid_bit_seen_d;
			bit_count_q    <= bit_count_d;
			shift_q        <= shift_d;
			time_ref_q     <= time_ref_d;
			error_code_q   <= error_code_d;
		end
	end

	a_error_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		error_hold_q |-> busy_q)
		else $error("error hold outside a frame");

	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(error_code_q == mfr_pkg::STATUS_TIMEOUT) |-> !busy_q)
		else $error("timeout code while a frame is open");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= LastCount)
		else $error("bit count beyond frame length");

	a_frame_closes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.frame_valid |=> !busy_q && bit_count_q == LastCount)
		else $error("frame completed but receiver still busy");

	a_error_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && error_hold_q && item.op == mfr_pkg::OP_EDGE
		|=> $stable(shift_q) && $stable(error_code_q) && error_hold_q)
		else $error("edge changed state while in error");

endmodule

FILE: hdl/manchester_frame_receiver.sv
// ----------------------------------------------------------------------------
// Manchester frame receiver
// Decodes Manchester frames from a stream of timestamped line edge words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one word per line edge or timeout event. s_tuser is the
//   op (0 edge, 1 inactivity timeout), s_tdata carries the edge timestamp in
//   microseconds and the line level after the edge.
//   Master channel: exactly one result word per input word, carrying the
//   frame-complete flag in m_tuser and the frame, receiving flag and status
//   in m_tdata.
//   Configuration: cfg_we writes half_window_us (index 0) or late_limit_us
//   (index 1); other indexes are dropped. Write only while the block is idle.
// Timing:
//   From input acceptance to the result word there is one input stage and one
//   result stage. The decode is one subtract and two compares, so one word is
//   accepted every cycle while the master channel is not stalled.
//   When m_tready is low the result stage holds, the input stage fills and
//   then s_tready drops; no word is lost or repeated.
// Reset: arst_n clears both stages and the frame state; the receiver waits
//   for a rising edge to start a frame, with the reset window limits.
// ----------------------------------------------------------------------------
module manchester_frame_receiver #(
	parameter int FRAME_BITS = 34
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [31:0] edge_time, [32] line_level, [39:33] zero
	input  logic [mfr_pkg::InTdataWidth-1:0]       s_tdata,
	// [0] op
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [33:0] frame_data, [34] receiving, [36:35] status, [39:37] zero
	output logic [mfr_pkg::OutTdataWidth-1:0]      m_tdata,
	// [0] frame_valid
	output logic                                   m_tuser,
	input  logic                                   cfg_we,
	input  logic [mfr_pkg::CfgIndexWidth-1:0]      cfg_index,
	input  logic [mfr_pkg::CfgWidth-1:0]           cfg_wdata
);

	logic [mfr_pkg::CfgWidth-1:0] half_window_q;
	logic [mfr_pkg::CfgWidth-1:0] late_limit_q;

	logic                 valid_s1;
	mfr_pkg::item_t       item_s1;
	logic                 valid_s2;
	mfr_pkg::result_t     result_s2;

	mfr_pkg::result_t     result;
	logic                 out_free;
	logic                 advance;

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q <= mfr_pkg::HALF_WINDOW_RESET;
			late_limit_q  <= mfr_pkg::LATE_LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == mfr_pkg::REG_HALF_WINDOW) begin
				half_window_q <= cfg_wdata;
			end else if (cfg_index == mfr_pkg::REG_LATE_LIMIT) begin
				late_limit_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op         <= s_tuser;
			item_s1.edge_time  <= s_tdata[mfr_pkg::TimeWidth-1:0];
			item_s1.line_level <= s_tdata[mfr_pkg::TimeWidth];
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	mfr_core #(
		.FRAME_BITS(FRAME_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item          (item_s1),
		.half_window_us(half_window_q),
		.late_limit_us (late_limit_q),
		.result        (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.frame_valid;
	assign m_tdata  = mfr_pkg::OutTdataWidth'({result_s2.status, result_s2.receiving,
		result_s2.frame_data});

endmodule
